@@ hdl/mcsp_pkg.sv @@
`default_nettype none

package mcsp_pkg;

	localparam int MARGIN_LEFT_DEF  = 60;
	localparam int ITEM_DEPTH_DEF   = 2;
	localparam int VERTEX_DEPTH_DEF = 4;

	// Quotients beyond this bound all saturate the final coordinate alike.
	localparam logic [40:0] QUOT_CAP = 41'h100_0000_0000;

	localparam logic [2:0] REG_VIEW_START    = 3'd0;
	localparam logic [2:0] REG_VIEW_END      = 3'd1;
	localparam logic [2:0] REG_PLOT_WIDTH    = 3'd2;
	localparam logic [2:0] REG_VALUE_LOW     = 3'd3;
	localparam logic [2:0] REG_VALUE_HIGH    = 3'd4;
	localparam logic [2:0] REG_BAND_TOP_Y    = 3'd5;
	localparam logic [2:0] REG_BAND_BOTTOM_Y = 3'd6;
	localparam logic [2:0] REG_DEGENERATE_Y  = 3'd7;

	typedef struct packed {
		logic signed [31:0] view_start;
		logic signed [31:0] view_end;
		logic signed [16:0] plot_width;
		logic signed [31:0] value_low;
		logic signed [31:0] value_high;
		logic signed [31:0] band_top_y;
		logic signed [31:0] band_bottom_y;
		logic signed [31:0] degenerate_y;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [16:0] col;
		logic               past;
		logic               dec;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               move;
		logic               last;
	} vertex_t;

	function automatic logic signed [31:0] sat43(input logic signed [42:0] v);
		if (v > 43'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -43'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	// Pixel column: x / 65536 rounded to nearest, ties away from zero.
	function automatic logic signed [16:0] round_col(input logic signed [31:0] p);
		logic [32:0] u;
		logic [32:0] s;
		if (!p[31]) begin
			s = {1'b0, p} + 33'd32768;
			return s[32:16];
		end else begin
			u = {1'b0, ~p} + 33'd1;
			s = u + 33'd32768;
			return 17'd0 - s[32:16];
		end
	endfunction

	function automatic logic signed [31:0] col_vx(input logic signed [16:0] col);
		if (col > 17'sd32767) begin
			return 32'sh7fffffff;
		end else if (col < -17'sd32768) begin
			return 32'sh80000000;
		end else begin
			return {col[15:0], 16'h0000};
		end
	endfunction

endpackage

`default_nettype wire

@@ hdl/mcsp_fifo.sv @@
`default_nettype none

module mcsp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wdata,
	input  wire logic         rd,
	output logic [W-1:0]      rdata,
	output logic              full,
	output logic              empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/mcsp_muldiv.sv @@
`default_nettype none

module mcsp_muldiv
	import mcsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] c,
	output logic             done,
	output logic [40:0]      q
);

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_RND} mstate_t;

	mstate_t     state_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] c_q;
	logic [63:0] acc_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic [40:0] q_q;
	logic        done_q;
	logic [63:0] prod;
	logic [32:0] rem_sh;
	logic        fits;
	logic [32:0] rem_sub;
	logic        up;
	logic [64:0] qr;

	assign prod    = a_q * b_q;
	assign rem_sh  = {rem_q, acc_q[63]};
	assign fits    = (rem_sh >= {1'b0, c_q});
	assign rem_sub = rem_sh - {1'b0, c_q};
	assign up      = ({rem_q, 1'b0} >= {1'b0, c_q});
	assign qr      = {1'b0, acc_q} + 65'(up);

	assign done = done_q;
	assign q    = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						c_q     <= c;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					acc_q   <= prod;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= M_DIV;
				end
				M_DIV: begin
					// Dividend shifts out at the top while quotient bits enter below.
					acc_q <= {acc_q[62:0], fits};
					rem_q <= fits ? rem_sub[31:0] : rem_sh[31:0];
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= M_RND;
					end
				end
				M_RND: begin
					q_q     <= (qr > 65'(QUOT_CAP)) ? QUOT_CAP : qr[40:0];
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/mcsp_front.sv @@
`default_nettype none

module mcsp_front
	import mcsp_pkg::*;
#(
	parameter int MARGIN_LEFT = MARGIN_LEFT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] sample_time,
	input  wire logic signed [31:0] sample_value,
	input  wire logic               decimate,
	input  wire logic               last_sample,
	output logic                    item_wr,
	output item_t                   item_data,
	input  wire logic               item_full
);

	typedef enum logic [1:0] {F_IDLE, F_RUN, F_FIN, F_PUSH} fstate_t;

	localparam logic signed [31:0] BASE = 32'(MARGIN_LEFT * 65536);

	fstate_t            state_q;
	logic               negx_q;
	logic               negy_q;
	logic               degx_q;
	logic               degy_q;
	logic               past_q;
	logic               dec_q;
	logic               last_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;

	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [32:0] dh;
	logic signed [32:0] spanx;
	logic signed [32:0] spany;
	logic [32:0]        ax;
	logic [32:0]        ay;
	logic [32:0]        ah;
	logic               start;
	logic               done_x;
	logic               done_y;
	logic [40:0]        mx;
	logic [40:0]        my;
	logic signed [42:0] offx;
	logic signed [42:0] offy;
	logic signed [42:0] sumx;
	logic signed [42:0] sumy;

	assign dx    = 33'(sample_time) - 33'(cfg.view_start);
	assign dy    = 33'(sample_value) - 33'(cfg.value_low);
	assign dh    = 33'(cfg.band_bottom_y) - 33'(cfg.band_top_y);
	assign spanx = 33'(cfg.view_end) - 33'(cfg.view_start);
	assign spany = 33'(cfg.value_high) - 33'(cfg.value_low);
	assign ax    = dx[32] ? 33'd0 - dx : dx;
	assign ay    = dy[32] ? 33'd0 - dy : dy;
	assign ah    = dh[32] ? 33'd0 - dh : dh;

	assign full  = (state_q != F_IDLE);
	assign start = push && !full;

	mcsp_muldiv u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.a      (ax[31:0]),
		.b      ({cfg.plot_width[15:0], 16'h0000}),
		.c      (spanx[31:0]),
		.done   (done_x),
		.q      (mx)
	);

	mcsp_muldiv u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.a      (ay[31:0]),
		.b      (ah[31:0]),
		.c      (spany[31:0]),
		.done   (done_y),
		.q      (my)
	);

	assign offx = negx_q ? 43'sd0 - 43'(mx) : 43'(mx);
	assign offy = negy_q ? 43'sd0 - 43'(my) : 43'(my);
	assign sumx = 43'(BASE) + offx;
	assign sumy = 43'(cfg.band_bottom_y) - offy;

	assign item_wr        = (state_q == F_PUSH) && !item_full;
	assign item_data.px   = px_q;
	assign item_data.py   = py_q;
	assign item_data.col  = round_col(px_q);
	assign item_data.past = past_q;
	assign item_data.dec  = dec_q;
	assign item_data.last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						negx_q  <= dx[32];
						negy_q  <= dy[32] ^ dh[32];
						degx_q  <= (spanx <= 33'sd0) || (cfg.plot_width <= 17'sd0);
						degy_q  <= (spany <= 33'sd0);
						past_q  <= (sample_time > cfg.view_end);
						dec_q   <= decimate;
						last_q  <= last_sample;
						state_q <= F_RUN;
					end
				end
				F_RUN: begin
					// Both lanes have the same fixed latency.
					if (done_x && done_y) begin
						state_q <= F_FIN;
					end
				end
				F_FIN: begin
					px_q    <= degx_q ? BASE : sat43(sumx);
					py_q    <= degy_q ? cfg.degenerate_y : sat43(sumy);
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!item_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/mcsp_back.sv @@
`default_nettype none

module mcsp_back
	import mcsp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_empty,
	input  wire item_t item_data,
	output logic       item_pop,
	input  wire logic  vtx_full,
	output logic       vtx_push,
	output vertex_t    vtx_data
);

	typedef enum logic {B_IDLE, B_RUN} bstate_t;

	// Slot map: old-column flush, move, hold, step, state update, new-column flush.
	localparam logic [3:0] SLOT_MOVE = 4'd5;
	localparam logic [3:0] SLOT_HOLD = 4'd6;
	localparam logic [3:0] SLOT_STEP = 4'd7;
	localparam logic [3:0] SLOT_UPD  = 4'd8;
	localparam logic [3:0] SLOT_POST = 4'd9;
	localparam logic [3:0] SLOT_END  = 4'd13;

	bstate_t            state_q;
	logic [3:0]         slot_q;
	logic [13:0]        en_q;
	item_t              it_q;
	logic               act_q;
	logic [31:0]        idx_q;
	logic               started_q;
	logic               stopped_q;
	logic signed [16:0] column_x_q;
	logic signed [31:0] first_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic signed [31:0] lasty_q;
	logic [31:0]        minpos_q;
	logic [31:0]        maxpos_q;
	logic [31:0]        count_q;
	logic signed [31:0] pen_q;

	logic        pre_en;
	logic        mv_en;
	logic        pair_en;
	logic        post_en;
	logic [13:0] en_new;
	logic [2:0]  k;
	logic [13:0] later;
	logic        advance;
	logic        min_first;

	assign item_pop = (state_q == B_IDLE) && !item_empty;

	always_comb begin
		pre_en  = 1'b0;
		mv_en   = 1'b0;
		pair_en = 1'b0;
		post_en = 1'b0;
		if (!stopped_q) begin
			if (item_data.dec) begin
				if (item_data.past) begin
					pre_en  = started_q && !column_x_q[16];
					pair_en = started_q;
				end else begin
					mv_en   = !started_q;
					pre_en  = started_q && (item_data.col != column_x_q);
					post_en = item_data.last && !item_data.col[16];
				end
			end else begin
				mv_en   = !started_q;
				pair_en = started_q;
			end
		end
		en_new = {{5{post_en}}, 1'b0, {2{pair_en}}, mv_en, {5{pre_en}}};
	end

	assign min_first = (minpos_q < maxpos_q);
	assign k         = (slot_q >= SLOT_POST) ? 3'(slot_q - SLOT_POST) : slot_q[2:0];
	assign later     = en_q >> slot_q;

	always_comb begin
		vtx_data.x    = col_vx(column_x_q);
		vtx_data.y    = pen_q;
		vtx_data.move = 1'b0;
		vtx_data.last = (later[13:1] == 13'd0);
		if (slot_q == SLOT_MOVE) begin
			vtx_data.x    = it_q.px;
			vtx_data.y    = it_q.py;
			vtx_data.move = 1'b1;
		end else if (slot_q == SLOT_HOLD) begin
			vtx_data.x = it_q.px;
		end else if (slot_q == SLOT_STEP) begin
			vtx_data.x = it_q.px;
			vtx_data.y = it_q.py;
		end else begin
			unique case (k)
				3'd0:    vtx_data.y = pen_q;
				3'd1:    vtx_data.y = first_q;
				3'd2:    vtx_data.y = min_first ? min_q : max_q;
				3'd3:    vtx_data.y = min_first ? max_q : min_q;
				default: vtx_data.y = lasty_q;
			endcase
		end
	end

	assign vtx_push = (state_q == B_RUN) && (slot_q != SLOT_UPD) && en_q[slot_q] && !vtx_full;
	assign advance  = (state_q == B_RUN) &&
		((slot_q == SLOT_UPD) || !en_q[slot_q] || !vtx_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			slot_q     <= '0;
			en_q       <= '0;
			act_q      <= 1'b0;
			idx_q      <= '0;
			started_q  <= 1'b0;
			stopped_q  <= 1'b0;
			column_x_q <= -17'sd1;
			first_q    <= '0;
			min_q      <= '0;
			max_q      <= '0;
			lasty_q    <= '0;
			minpos_q   <= '0;
			maxpos_q   <= '0;
			count_q    <= '0;
			pen_q      <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!item_empty) begin
						it_q    <= item_data;
						en_q    <= en_new;
						act_q   <= !stopped_q;
						idx_q   <= count_q;
						slot_q  <= '0;
						state_q <= B_RUN;
						if (!stopped_q) begin
							count_q <= count_q + 32'd1;
						end
					end
				end
				B_RUN: begin
					// The series clear below owns the pen on the closing slot of a last sample.
					if (vtx_push && !(slot_q == SLOT_END && it_q.last)) begin
						pen_q <= vtx_data.y;
					end
					if (slot_q == SLOT_UPD && act_q) begin
						if (it_q.dec) begin
							if (it_q.past) begin
								stopped_q <= 1'b1;
							end else if (!started_q || it_q.col != column_x_q) begin
								started_q  <= 1'b1;
								column_x_q <= it_q.col;
								first_q    <= it_q.py;
								min_q      <= it_q.py;
								max_q      <= it_q.py;
								lasty_q    <= it_q.py;
								minpos_q   <= started_q ? idx_q : 32'd0;
								maxpos_q   <= started_q ? idx_q : 32'd0;
							end else begin
								if (it_q.py < min_q) begin
									min_q    <= it_q.py;
									minpos_q <= idx_q;
								end
								if (it_q.py > max_q) begin
									max_q    <= it_q.py;
									maxpos_q <= idx_q;
								end
								lasty_q <= it_q.py;
							end
						end else begin
							if (!started_q) begin
								started_q <= 1'b1;
							end else if (it_q.past) begin
								stopped_q <= 1'b1;
							end
						end
					end
					if (advance) begin
						slot_q <= slot_q + 4'd1;
						if (slot_q == SLOT_END) begin
							state_q <= B_IDLE;
							if (it_q.last) begin
								started_q  <= 1'b0;
								stopped_q  <= 1'b0;
								column_x_q <= -17'sd1;
								first_q    <= '0;
								min_q      <= '0;
								max_q      <= '0;
								lasty_q    <= '0;
								minpos_q   <= '0;
								maxpos_q   <= '0;
								count_q    <= '0;
								pen_q      <= '0;
							end
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_push |-> !vtx_full) else $error("vertex pushed into a full queue");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |=> (state_q == B_RUN)) else $error("item popped without starting");

	a_upd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RUN && slot_q == SLOT_UPD) |-> !vtx_push)
		else $error("vertex emitted in update slot");

endmodule

`default_nettype wire

@@ hdl/minmax_column_step_plot.sv @@
`default_nettype none

// Step-plot vertex generator with per-pixel-column min/max decimation. Samples are written
// through a queue-like port (push/full) and path vertices are read from a queue-like port
// (empty/pop); a plain write port loads the eight view registers, which must only change
// while the block is idle. The front end maps each sample to Q16.16 pixel x and y with the
// 64-step restoring divider that the x and y lanes run side by side, and accepts no new
// sample until the last one is queued. Mapped samples wait in a short queue; the back end
// runs the series state (start, stop, open column with first/min/max/last) and emits at
// most one vertex per cycle into the output queue, stalling while it is full, up to ten
// vertices per sample, overlapping the next sample's mapping.
module minmax_column_step_plot
	import mcsp_pkg::*;
#(
	parameter int MARGIN_LEFT  = MARGIN_LEFT_DEF,
	parameter int ITEM_DEPTH   = ITEM_DEPTH_DEF,
	parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] sample_time,
	input  wire logic signed [31:0] sample_value,
	input  wire logic               decimate,
	input  wire logic               last_sample,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      vertex_x,
	output logic signed [31:0]      vertex_y,
	output logic                    vertex_move,
	output logic                    last_vertex
);

	cfg_t    cfg_q;
	logic    item_wr;
	item_t   item_w;
	item_t   item_r;
	logic    item_full;
	logic    item_empty;
	logic    item_pop;
	logic    vtx_push;
	vertex_t vtx_w;
	vertex_t vtx_r;
	logic    vtx_full;

	// Configuration registers; a write lands on the following clock edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view_start    <= 32'sd0;
			cfg_q.view_end      <= 32'sd1000;
			cfg_q.plot_width    <= 17'sd800;
			cfg_q.value_low     <= 32'sd0;
			cfg_q.value_high    <= 32'sd1000;
			cfg_q.band_top_y    <= 32'sd0;
			cfg_q.band_bottom_y <= 32'sd6553600;
			cfg_q.degenerate_y  <= 32'sd3276800;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_VIEW_START:    cfg_q.view_start    <= cfg_data;
				REG_VIEW_END:      cfg_q.view_end      <= cfg_data;
				REG_PLOT_WIDTH:    cfg_q.plot_width    <= cfg_data[16:0];
				REG_VALUE_LOW:     cfg_q.value_low     <= cfg_data;
				REG_VALUE_HIGH:    cfg_q.value_high    <= cfg_data;
				REG_BAND_TOP_Y:    cfg_q.band_top_y    <= cfg_data;
				REG_BAND_BOTTOM_Y: cfg_q.band_bottom_y <= cfg_data;
				REG_DEGENERATE_Y:  cfg_q.degenerate_y  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: coordinate mapping and column classification.
	mcsp_front #(
		.MARGIN_LEFT (MARGIN_LEFT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.sample_time  (sample_time),
		.sample_value (sample_value),
		.decimate     (decimate),
		.last_sample  (last_sample),
		.item_wr      (item_wr),
		.item_data    (item_w),
		.item_full    (item_full)
	);

	// The item queue lets the mapper start the next sample while a flush burst drains.
	mcsp_fifo #(
		.W     ($bits(item_t)),
		.DEPTH (ITEM_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (item_wr),
		.wdata  (item_w),
		.rd     (item_pop),
		.rdata  (item_r),
		.full   (item_full),
		.empty  (item_empty)
	);

	// Back end: series state and vertex sequencing.
	mcsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_empty (item_empty),
		.item_data  (item_r),
		.item_pop   (item_pop),
		.vtx_full   (vtx_full),
		.vtx_push   (vtx_push),
		.vtx_data   (vtx_w)
	);

	// Output queue; the head word is shown on the result ports while not empty.
	mcsp_fifo #(
		.W     ($bits(vertex_t)),
		.DEPTH (VERTEX_DEPTH)
	) u_vtx_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (vtx_push),
		.wdata  (vtx_w),
		.rd     (pop),
		.rdata  (vtx_r),
		.full   (vtx_full),
		.empty  (empty)
	);

	assign vertex_x    = vtx_r.x;
	assign vertex_y    = vtx_r.y;
	assign vertex_move = vtx_r.move;
	assign last_vertex = vtx_r.last;

endmodule

`default_nettype wire
